FILE: rtl/core/rycc_pkg.sv
`default_nettype none

package rycc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W      = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int HALF_W     = COL_W - 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int OFFSET_W   = 22;
    localparam int SAMPLE_W   = 8;
    localparam int PLANE_W    = 2;
    localparam int COMP_W     = 8;
    localparam int CHROMA_W   = 2 * SAMPLE_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRECISION_MODE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_FLOOR     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_CEILING   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_CEILING = 3'd5;

    localparam logic [DIM_W-1:0]    RESET_IMAGE_WIDTH    = 12'd640;
    localparam logic [DIM_W-1:0]    RESET_IMAGE_HEIGHT   = 12'd480;
    localparam logic                RESET_PRECISION_MODE = 1'b1;
    localparam logic [SAMPLE_W-1:0] RESET_CLIP_FLOOR     = 8'd16;
    localparam logic [SAMPLE_W-1:0] RESET_LUMA_CEILING   = 8'd235;
    localparam logic [SAMPLE_W-1:0] RESET_CHROMA_CEILING = 8'd240;

    localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int NUM_PROD = 9;
    localparam int COEF_W   = 9;
    localparam int PROD_W   = 17;
    localparam int SUM_W    = 19;
    localparam int VAL_W    = 11;
    localparam int ACC_W    = SAMPLE_W + 2;

    // y row, cb row, cr row; each row weights red, green, blue
    localparam logic signed [COEF_W-1:0] COEF_FINE [NUM_PROD] = '{
        9'sd66,  9'sd129, 9'sd25,
        -9'sd38, -9'sd74, 9'sd112,
        9'sd112, -9'sd94, -9'sd18
    };
    localparam logic signed [COEF_W-1:0] COEF_COARSE [NUM_PROD] = '{
        9'sd33,  9'sd65,  9'sd13,
        -9'sd19, -9'sd37, 9'sd56,
        9'sd56,  -9'sd47, -9'sd9
    };

    localparam logic signed [VAL_W-1:0] LUMA_BIAS   = 11'sd16;
    localparam logic signed [VAL_W-1:0] CHROMA_BIAS = 11'sd128;

    typedef struct packed {
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic                precision_mode;
        logic [SAMPLE_W-1:0] clip_floor;
        logic [SAMPLE_W-1:0] luma_ceiling;
        logic [SAMPLE_W-1:0] chroma_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [HALF_W-1:0]   col_half;
        logic                col_odd;
        logic                row_even;
        logic                chroma;
        logic                frame_end;
        logic [OFFSET_W-1:0] luma_off;
        logic [OFFSET_W-1:0] chroma_off;
    } item_meta_t;

    typedef struct packed {
        item_meta_t        meta;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } queue_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/rycc_if.sv
`default_nettype none

interface rycc_pixel_if;
    import rycc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface rycc_result_if;
    import rycc_pkg::*;

    logic                valid;
    logic                ready;
    logic [PLANE_W-1:0]  plane;
    logic [SAMPLE_W-1:0] sample_value;
    logic [OFFSET_W-1:0] plane_offset;
    logic                last_of_pixel;
    logic                frame_done;

    modport source (output valid, plane, sample_value, plane_offset, last_of_pixel,
                    frame_done, input ready);
    modport sink (input valid, plane, sample_value, plane_offset, last_of_pixel,
                  frame_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rycc_front.sv
`default_nettype none

module rycc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rycc_pkg::cfg_t        cfg,
    rycc_pixel_if.sink                 pixels,
    input  wire logic                  q_full,
    output logic                       push,
    output rycc_pkg::queue_entry_t     entry
);
    import rycc_pkg::*;

    localparam int CMP_W = COL_W + 1;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [OFFSET_W-1:0] luma_pos_reg, luma_pos_next;

    logic [DIM_W-1:0]    w_sat;
    logic [DIM_W-1:0]    h_sat;
    logic [CMP_W-1:0]    col_plus;
    logic [ROW_W:0]      row_plus;
    logic                row_end;
    logic                frame_end;
    logic [OFFSET_W-1:0] row_base;

    // saturate geometry to the supported range
    always_comb
    begin
        priority if (cfg.image_width == '0)
            w_sat = DIM_W'(1);
        else if (cfg.image_width > DIM_W'(MAX_WIDTH))
            w_sat = DIM_W'(MAX_WIDTH);
        else
            w_sat = cfg.image_width;

        priority if (cfg.image_height == '0)
            h_sat = DIM_W'(1);
        else if (cfg.image_height > DIM_W'(MAX_HEIGHT))
            h_sat = DIM_W'(MAX_HEIGHT);
        else
            h_sat = cfg.image_height;
    end

    assign col_plus  = CMP_W'(col_reg) + CMP_W'(1);
    assign row_plus  = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);
    assign row_end   = col_plus >= CMP_W'(w_sat);
    assign frame_end = row_end && (DIM_W'(row_plus) >= h_sat);

    assign row_base = OFFSET_W'(OFFSET_W'(row_reg[ROW_W-1:1]) *
                                OFFSET_W'(w_sat[DIM_W-1:1]));

    assign pixels.ready = !q_full;
    assign push         = pixels.valid && !q_full;

    always_comb
    begin
        entry.red             = pixels.red;
        entry.green           = pixels.green;
        entry.blue            = pixels.blue;
        entry.meta.col_half   = col_reg[COL_W-1:1];
        entry.meta.col_odd    = col_reg[0];
        entry.meta.row_even   = !row_reg[0];
        entry.meta.chroma     = row_reg[0] && col_reg[0];
        entry.meta.frame_end  = frame_end;
        entry.meta.luma_off   = luma_pos_reg;
        entry.meta.chroma_off = row_base + OFFSET_W'(col_reg[COL_W-1:1]);
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        luma_pos_next = luma_pos_reg;
        if (push)
        begin
            priority if (frame_end)
            begin
                col_next      = '0;
                row_next      = '0;
                luma_pos_next = '0;
            end
            else if (row_end)
            begin
                col_next      = '0;
                row_next      = row_plus[ROW_W-1:0];
                luma_pos_next = luma_pos_reg + OFFSET_W'(1);
            end
            else
            begin
                col_next      = col_plus[COL_W-1:0];
                luma_pos_next = luma_pos_reg + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            luma_pos_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            luma_pos_reg <= luma_pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rycc_queue.sv
`default_nettype none

module rycc_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire rycc_pkg::queue_entry_t push_entry,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       empty,
    output rycc_pkg::queue_entry_t     head
);
    import rycc_pkg::*;

    queue_entry_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        priority if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rycc_back.sv
`default_nettype none

module rycc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rycc_pkg::cfg_t         cfg,
    input  wire logic                   q_empty,
    input  wire rycc_pkg::queue_entry_t head,
    output logic                        pop,
    rycc_result_if.source               results
);
    import rycc_pkg::*;

    function automatic logic [SAMPLE_W-1:0] clip_sample(
        input logic signed [VAL_W-1:0] v,
        input logic [SAMPLE_W-1:0]     lo,
        input logic [SAMPLE_W-1:0]     hi
    );
        logic signed [VAL_W-1:0] lo_s;
        logic signed [VAL_W-1:0] hi_s;
        lo_s = $signed(VAL_W'(lo));
        hi_s = $signed(VAL_W'(hi));
        priority if (v < lo_s)
            return lo;
        else if (v > hi_s)
            return hi;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // product stage
    logic                     s1_valid_reg;
    item_meta_t               s1_meta_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [NUM_PROD];
    logic signed [PROD_W-1:0] prod_next [NUM_PROD];

    // clip stage
    logic                s2_valid_reg;
    item_meta_t          s2_meta_reg;
    logic [SAMPLE_W-1:0] s2_y_reg, s2_cb_reg, s2_cr_reg;
    logic [SAMPLE_W-1:0] y_next, cb_next, cr_next;
    logic [CHROMA_W-1:0] up_reg, upl_reg;

    // line store, even and odd columns split so both columns of a pair read together
    logic [CHROMA_W-1:0] line_even_mem [LINE_DEPTH];
    logic [CHROMA_W-1:0] line_odd_mem [LINE_DEPTH];
    logic [CHROMA_W-1:0] left_reg;

    // result group
    logic                grp_valid_reg;
    logic [PLANE_W-1:0]  grp_idx_reg, grp_idx_next;
    logic [SAMPLE_W-1:0] grp_y_reg, grp_cb_reg, grp_cr_reg;
    logic [OFFSET_W-1:0] grp_luma_off_reg, grp_chroma_off_reg;
    logic                grp_chroma_reg, grp_frame_end_reg;
    logic [ACC_W-1:0]    cb_sum, cr_sum;

    logic grp_last, out_take, grp_free, adv_s2, adv_s1, line_we, grp_load;

    assign grp_last = !grp_chroma_reg || (grp_idx_reg == PLANE_CR);
    assign out_take = results.valid && results.ready;
    assign grp_free = !grp_valid_reg || (results.ready && grp_last);
    assign adv_s2   = !s2_valid_reg || grp_free;
    assign adv_s1   = !s1_valid_reg || adv_s2;
    assign pop      = !q_empty && adv_s1;
    assign grp_load = grp_free && s2_valid_reg;
    assign line_we  = grp_load && s2_meta_reg.row_even;

    for (genvar k = 0; k < NUM_PROD; k++)
    begin : g_prod
        logic [COMP_W-1:0] comp;
        assign comp = (k % 3 == 0) ? head.red : ((k % 3 == 1) ? head.green : head.blue);
        assign prod_next[k] = cfg.precision_mode ?
            PROD_W'($signed({1'b0, comp})) * PROD_W'(COEF_FINE[k]) :
            PROD_W'($signed({1'b0, comp})) * PROD_W'(COEF_COARSE[k]);
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] y_sum, cb_sum_s, cr_sum_s;
        logic signed [SUM_W-1:0] y_sh, cb_sh, cr_sh;
        y_sum    = SUM_W'(s1_prod_reg[0]) + SUM_W'(s1_prod_reg[1]) + SUM_W'(s1_prod_reg[2]);
        cb_sum_s = SUM_W'(s1_prod_reg[3]) + SUM_W'(s1_prod_reg[4]) + SUM_W'(s1_prod_reg[5]);
        cr_sum_s = SUM_W'(s1_prod_reg[6]) + SUM_W'(s1_prod_reg[7]) + SUM_W'(s1_prod_reg[8]);
        if (cfg.precision_mode)
        begin
            y_sh  = y_sum >>> 8;
            cb_sh = cb_sum_s >>> 8;
            cr_sh = cr_sum_s >>> 8;
        end
        else
        begin
            y_sh  = y_sum >>> 7;
            cb_sh = cb_sum_s >>> 7;
            cr_sh = cr_sum_s >>> 7;
        end
        y_next  = clip_sample(VAL_W'(y_sh) + LUMA_BIAS, cfg.clip_floor, cfg.luma_ceiling);
        cb_next = clip_sample(VAL_W'(cb_sh) + CHROMA_BIAS, cfg.clip_floor, cfg.chroma_ceiling);
        cr_next = clip_sample(VAL_W'(cr_sh) + CHROMA_BIAS, cfg.clip_floor, cfg.chroma_ceiling);
    end

    // 2x2 average over current, left, upper and upper-left chroma
    assign cb_sum = ACC_W'(s2_cb_reg) + ACC_W'(left_reg[CHROMA_W-1:SAMPLE_W]) +
                    ACC_W'(up_reg[CHROMA_W-1:SAMPLE_W]) + ACC_W'(upl_reg[CHROMA_W-1:SAMPLE_W]);
    assign cr_sum = ACC_W'(s2_cr_reg) + ACC_W'(left_reg[SAMPLE_W-1:0]) +
                    ACC_W'(up_reg[SAMPLE_W-1:0]) + ACC_W'(upl_reg[SAMPLE_W-1:0]);

    always_comb
    begin
        unique case (grp_idx_reg)
            PLANE_Y:  grp_idx_next = PLANE_CB;
            PLANE_CB: grp_idx_next = PLANE_CR;
            default:  grp_idx_next = PLANE_Y;
        endcase
    end

    always_comb
    begin
        results.valid         = grp_valid_reg;
        results.plane         = grp_idx_reg;
        results.last_of_pixel = grp_last;
        results.frame_done    = grp_last && grp_frame_end_reg;
        unique case (grp_idx_reg)
            PLANE_CB:
            begin
                results.sample_value = grp_cb_reg;
                results.plane_offset = grp_chroma_off_reg;
            end
            PLANE_CR:
            begin
                results.sample_value = grp_cr_reg;
                results.plane_offset = grp_chroma_off_reg;
            end
            default:
            begin
                results.sample_value = grp_y_reg;
                results.plane_offset = grp_luma_off_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= PLANE_Y;
        end
        else
        begin
            if (adv_s1)
                s1_valid_reg <= pop;
            if (adv_s2)
                s2_valid_reg <= s1_valid_reg;
            if (grp_free)
                grp_valid_reg <= s2_valid_reg;
            if (grp_free)
                grp_idx_reg <= PLANE_Y;
            else if (out_take)
                grp_idx_reg <= grp_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_meta_reg <= head.meta;
            for (int k = 0; k < NUM_PROD; k++)
                s1_prod_reg[k] <= prod_next[k];
        end
        if (adv_s2 && s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_y_reg    <= y_next;
            s2_cb_reg   <= cb_next;
            s2_cr_reg   <= cr_next;
        end
        if (grp_load)
        begin
            left_reg           <= {s2_cb_reg, s2_cr_reg};
            grp_y_reg          <= s2_y_reg;
            grp_cb_reg         <= cb_sum[ACC_W-1:2];
            grp_cr_reg         <= cr_sum[ACC_W-1:2];
            grp_luma_off_reg   <= s2_meta_reg.luma_off;
            grp_chroma_off_reg <= s2_meta_reg.chroma_off;
            grp_chroma_reg     <= s2_meta_reg.chroma;
            grp_frame_end_reg  <= s2_meta_reg.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we && !s2_meta_reg.col_odd)
            line_even_mem[s2_meta_reg.col_half] <= {s2_cb_reg, s2_cr_reg};
        if (adv_s2 && s1_valid_reg)
            upl_reg <= line_even_mem[s1_meta_reg.col_half];
    end

    always_ff @(posedge clk)
    begin
        if (line_we && s2_meta_reg.col_odd)
            line_odd_mem[s2_meta_reg.col_half] <= {s2_cb_reg, s2_cr_reg};
        if (adv_s2 && s1_valid_reg)
            up_reg <= line_odd_mem[s1_meta_reg.col_half];
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !grp_last |=> grp_valid_reg)
        else $error("result group dropped before its last request");

    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_done |-> results.last_of_pixel)
        else $error("frame end flagged on a non-final request");

    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.plane != PLANE_Y) |-> grp_chroma_reg)
        else $error("chroma request for a pixel without chroma");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !adv_s2 |=> $stable(up_reg) && $stable(upl_reg))
        else $error("line store data changed under a stalled stage");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rgb_to_ycbcr_420_converter.sv
// flow: a pixel's luma request is offered once it has passed the queue and the product,
//   clip and result-group registers; its cb and cr requests follow, each as the one before is taken
// throughput: one request per cycle at the output while results.ready stays high, so one
//   request for a luma-only pixel and three for a pixel that closes a 2x2 block
// reset: config registers return to their defaults, position counters clear, line store
//   keeps its contents
`default_nettype none

module rgb_to_ycbcr_420_converter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    rycc_pixel_if.sink                               pixels,
    rycc_result_if.source                            results,
    input  wire logic                                cfg_we,
    input  wire logic [rycc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rycc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rycc_pkg::*;

    cfg_t         cfg_reg;
    queue_entry_t push_entry;
    queue_entry_t head;
    logic         push, pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height   <= RESET_IMAGE_HEIGHT;
            cfg_reg.precision_mode <= RESET_PRECISION_MODE;
            cfg_reg.clip_floor     <= RESET_CLIP_FLOOR;
            cfg_reg.luma_ceiling   <= RESET_LUMA_CEILING;
            cfg_reg.chroma_ceiling <= RESET_CHROMA_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[DIM_W-1:0];
                CFG_PRECISION_MODE: cfg_reg.precision_mode <= cfg_data[0];
                CFG_CLIP_FLOOR:     cfg_reg.clip_floor     <= cfg_data[SAMPLE_W-1:0];
                CFG_LUMA_CEILING:   cfg_reg.luma_ceiling   <= cfg_data[SAMPLE_W-1:0];
                CFG_CHROMA_CEILING: cfg_reg.chroma_ceiling <= cfg_data[SAMPLE_W-1:0];
                default:            ;
            endcase
        end
    end

    rycc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pixels (pixels),
        .q_full (q_full),
        .push   (push),
        .entry  (push_entry)
    );

    rycc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    rycc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

FILE: tb/sv/ycbcr_checker.sv
module ycbcr_checker
    import rycc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    rycc_pixel_if                  pixels,
    rycc_result_if                 results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     line_row
);

    typedef struct packed {
        logic [PLANE_W-1:0]  plane;
        logic [SAMPLE_W-1:0] value;
        logic [OFFSET_W-1:0] offset;
        logic                last_of_pixel;
        logic                frame_done;
    } sample_t;

    sample_t expected_samples[$];
    int      error_count;

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic                fine_mode;
    logic [SAMPLE_W-1:0] floor_reg;
    logic [SAMPLE_W-1:0] luma_ceil_reg;
    logic [SAMPLE_W-1:0] chroma_ceil_reg;

    int                  col_cnt;
    int                  row_cnt;
    logic [OFFSET_W-1:0] luma_pos;
    logic [CHROMA_W-1:0] left_chroma;
    logic [CHROMA_W-1:0] upper_chroma [MAX_WIDTH];

    function automatic logic [SAMPLE_W-1:0] clamp(input int v, input int lo, input int hi);
        if (v < lo)
            return lo[SAMPLE_W-1:0];
        if (v > hi)
            return hi[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic convert_pixel(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                                 input logic [COMP_W-1:0] b);
        int                  ri;
        int                  gi;
        int                  bi;
        int                  w;
        int                  h;
        int                  y;
        int                  cb;
        int                  cr;
        int                  n;
        logic [SAMPLE_W-1:0] yc;
        logic [SAMPLE_W-1:0] cbc;
        logic [SAMPLE_W-1:0] crc;
        logic [CHROMA_W-1:0] up;
        logic [CHROMA_W-1:0] upl;
        logic [OFFSET_W-1:0] coff;
        logic                row_end;
        logic                frame_end;
        sample_t             batch [3];
        ri = r;
        gi = g;
        bi = b;
        w = width_reg;
        h = height_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h < 1)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        if (fine_mode)
        begin
            y  = 16 + ((66 * ri + 129 * gi + 25 * bi) >>> 8);
            cb = 128 + ((-38 * ri - 74 * gi + 112 * bi) >>> 8);
            cr = 128 + ((112 * ri - 94 * gi - 18 * bi) >>> 8);
        end
        else
        begin
            y  = 16 + ((33 * ri + 65 * gi + 13 * bi) >>> 7);
            cb = 128 + ((-19 * ri - 37 * gi + 56 * bi) >>> 7);
            cr = 128 + ((56 * ri - 47 * gi - 9 * bi) >>> 7);
        end
        yc  = clamp(y, floor_reg, luma_ceil_reg);
        cbc = clamp(cb, floor_reg, chroma_ceil_reg);
        crc = clamp(cr, floor_reg, chroma_ceil_reg);

        batch[0] = '{PLANE_Y, yc, luma_pos, 1'b0, 1'b0};
        n = 1;
        // odd row, odd column closes a 2x2 block
        if (row_cnt[0] && col_cnt[0] && col_cnt < MAX_WIDTH)
        begin
            up   = upper_chroma[col_cnt];
            upl  = upper_chroma[col_cnt - 1];
            coff = OFFSET_W'((row_cnt >> 1) * (w >> 1) + (col_cnt >> 1));
            batch[1] = '{PLANE_CB,
                         SAMPLE_W'((int'(cbc) + left_chroma[15:8] + up[15:8] + upl[15:8]) >> 2),
                         coff, 1'b0, 1'b0};
            batch[2] = '{PLANE_CR,
                         SAMPLE_W'((int'(crc) + left_chroma[7:0] + up[7:0] + upl[7:0]) >> 2),
                         coff, 1'b0, 1'b0};
            n = 3;
        end

        left_chroma = {cbc, crc};
        if (!row_cnt[0] && col_cnt < MAX_WIDTH)
            upper_chroma[col_cnt] = left_chroma;

        row_end   = (col_cnt + 1 >= w);
        frame_end = row_end && (row_cnt + 1 >= h);
        batch[n-1].last_of_pixel = 1'b1;
        batch[n-1].frame_done    = frame_end;
        for (int i = 0; i < n; i++)
            expected_samples.push_back(batch[i]);

        if (frame_end)
        begin
            col_cnt  = 0;
            row_cnt  = 0;
            luma_pos = '0;
        end
        else
        begin
            luma_pos = luma_pos + 1'b1;
            if (row_end)
            begin
                col_cnt = 0;
                row_cnt = row_cnt + 1;
            end
            else
                col_cnt = col_cnt + 1;
        end
    endtask

    task automatic check_sample();
        sample_t got;
        sample_t want;
        got = {results.plane, results.sample_value, results.plane_offset,
               results.last_of_pixel, results.frame_done};
        if (expected_samples.size() == 0)
        begin
            $display("%0t: unexpected request plane %0d value %0d offset %0d last %0b done %0b",
                     $time, got.plane, got.value, got.offset, got.last_of_pixel,
                     got.frame_done);
            error_count++;
        end
        else
        begin
            want = expected_samples.pop_front();
            if (got !== want)
            begin
                $display({"%0t: mismatch expected plane %0d value %0d offset %0d last %0b ",
                          "done %0b, actual plane %0d value %0d offset %0d last %0b done %0b"},
                         $time, want.plane, want.value, want.offset, want.last_of_pixel,
                         want.frame_done, got.plane, got.value, got.offset,
                         got.last_of_pixel, got.frame_done);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       = RESET_IMAGE_WIDTH;
            height_reg      = RESET_IMAGE_HEIGHT;
            fine_mode       = RESET_PRECISION_MODE;
            floor_reg       = RESET_CLIP_FLOOR;
            luma_ceil_reg   = RESET_LUMA_CEILING;
            chroma_ceil_reg = RESET_CHROMA_CEILING;
            col_cnt         = 0;
            row_cnt         = 0;
            luma_pos        = '0;
            error_count     = 0;
            expected_samples.delete();
            mismatches  <= 0;
            outstanding <= 0;
            line_row    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg       = cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:   height_reg      = cfg_data[DIM_W-1:0];
                    CFG_PRECISION_MODE: fine_mode       = cfg_data[0];
                    CFG_CLIP_FLOOR:     floor_reg       = cfg_data[SAMPLE_W-1:0];
                    CFG_LUMA_CEILING:   luma_ceil_reg   = cfg_data[SAMPLE_W-1:0];
                    CFG_CHROMA_CEILING: chroma_ceil_reg = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (pixels.valid && pixels.ready)
                convert_pixel(pixels.red, pixels.green, pixels.blue);
            if (results.valid && results.ready)
                check_sample();
            mismatches  <= error_count;
            outstanding <= expected_samples.size();
            line_row    <= row_cnt;
        end
    end

endmodule

FILE: tb/sv/tb_rgb_to_ycbcr_420_converter.sv
module tb_rgb_to_ycbcr_420_converter;
    import rycc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 48;
    localparam int LONG_HOLD    = 300;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int line_row;
    int stall_pct = 0;
    int send_idle_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;

    // row 0 at reset geometry, then the tail of a mid-frame shrink, then crossed bounds
    logic [23:0] directed_rgb [22] = '{
        24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
        24'hffff00, 24'hff00ff, 24'h00ffff, 24'h808080,
        24'hff0000, 24'h0000ff, 24'hffffff, 24'haa5533,
        24'h000000, 24'hffffff, 24'h00ff00, 24'hff00ff, 24'h0000ff,
        24'h123456, 24'hfedcba, 24'h7f7f7f, 24'h01fe80
    };

    rycc_pixel_if  pix_ch ();
    rycc_result_if res_ch ();

    rgb_to_ycbcr_420_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ycbcr_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pix_ch),
        .results     (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .line_row    (line_row)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls plus one long hold
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_rgb_to_ycbcr_420_converter: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COMP_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [23:0] rgb);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= rgb[23:16];
        pix_ch.green <= rgb[15:8];
        pix_ch.blue  <= rgb[7:0];
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic settle();
        pix_ch.valid <= 1'b0;
        cfg_we       <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int w_val;
        int h_val;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pix_ch.valid  = 1'b0;
        pix_ch.red    = '0;
        pix_ch.green  = '0;
        pix_ch.blue   = '0;
        res_ch.ready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 9; i++)
            send_pixel(directed_rgb[i]);
        settle();
        // shrink geometry partway through row 0
        set_reg(CFG_IMAGE_WIDTH, 3);
        set_reg(CFG_IMAGE_HEIGHT, 2);
        cfg_we <= 1'b0;
        for (int i = 9; i < 13; i++)
            send_pixel(directed_rgb[i]);
        settle();
        // floor above both ceilings, coarse coefficients, odd trailing row and column
        set_reg(CFG_IMAGE_WIDTH, 3);
        set_reg(CFG_IMAGE_HEIGHT, 3);
        set_reg(CFG_PRECISION_MODE, 0);
        set_reg(CFG_CLIP_FLOOR, 200);
        set_reg(CFG_LUMA_CEILING, 50);
        set_reg(CFG_CHROMA_CEILING, 60);
        cfg_we <= 1'b0;
        for (int i = 13; i < 22; i++)
            send_pixel(directed_rgb[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == 0)
            begin
                w_val = 4095;
                h_val = 1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       w_val = 0;
                    1:       w_val = 1;
                    2:       w_val = 2048;
                    3:       w_val = 2047;
                    default: w_val = $urandom_range(2, 12);
                endcase
                if (p == PHASES - 1)
                    h_val = $urandom_range(0, 1) ? 2048 : 4095;
                else
                    case ($urandom_range(0, 5))
                        0:       h_val = 0;
                        1:       h_val = 1;
                        default: h_val = $urandom_range(2, 6);
                    endcase
            end
            // line store stays consistent only if geometry moves while in row 0
            if (line_row == 0)
            begin
                set_reg(CFG_IMAGE_WIDTH, w_val);
                set_reg(CFG_IMAGE_HEIGHT, h_val);
            end
            if (p == 0)
            begin
                set_reg(CFG_PRECISION_MODE, 1);
                set_reg(CFG_CLIP_FLOOR, 0);
                set_reg(CFG_LUMA_CEILING, 255);
                set_reg(CFG_CHROMA_CEILING, 255);
            end
            else
            begin
                set_reg(CFG_PRECISION_MODE, $urandom_range(0, 1));
                set_reg(CFG_CLIP_FLOOR, $urandom_range(0, 3) == 0 ? rand_level() : 16);
                set_reg(CFG_LUMA_CEILING, $urandom_range(0, 3) == 0 ? rand_level() : 235);
                set_reg(CFG_CHROMA_CEILING, $urandom_range(0, 3) == 0 ? rand_level() : 240);
            end
            cfg_we <= 1'b0;
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 87;
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct    <= 14;
                end
            endcase
            if (p == 0)
                hold_req <= ~hold_req;
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel({rand_comp(), rand_comp(), rand_comp()});
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_rgb_to_ycbcr_420_converter: PASS");
        else
            $display("tb_rgb_to_ycbcr_420_converter: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rycc_pkg.sv
rtl/core/rycc_if.sv
rtl/core/rycc_front.sv
rtl/core/rycc_queue.sv
rtl/core/rycc_back.sv
rtl/core/rgb_to_ycbcr_420_converter.sv
tb/sv/ycbcr_checker.sv
tb/sv/tb_rgb_to_ycbcr_420_converter.sv
